@@ sv/ccs_pkg.sv @@
package ccs_pkg;

  // Width of the saturating removed-control counter.
  localparam int unsigned COUNT_WIDTH = 16;
  // Width of the count carried on each result transaction.
  localparam int unsigned RptWidth    = 16;
  localparam int unsigned CountExtW   = (COUNT_WIDTH > RptWidth) ? COUNT_WIDTH : RptWidth;

  // Upper bound on the result transactions one input byte can cause.
  localparam int unsigned MaxOut = 6;
  localparam int unsigned OutIdxW = $clog2(MaxOut + 1);

  // Lead and range bytes of the sequences that are recognised.
  localparam logic [7:0] LeadC1     = 8'hC2;
  localparam logic [7:0] LeadE2     = 8'hE2;
  localparam logic [7:0] C1Low      = 8'h80;
  localparam logic [7:0] C1High     = 8'h9F;
  localparam logic [7:0] Mid80      = 8'h80;
  localparam logic [7:0] Mid81      = 8'h81;
  localparam logic [7:0] EmbedLow   = 8'hAA;
  localparam logic [7:0] EmbedHigh  = 8'hAE;
  localparam logic [7:0] IsoLow     = 8'hA6;
  localparam logic [7:0] IsoHigh    = 8'hA9;
  localparam logic [7:0] CodeDel    = 8'h7F;
  localparam logic [7:0] CodeSpace  = 8'h20;
  localparam logic [7:0] CodeTab    = 8'h09;
  localparam logic [7:0] CodeLf     = 8'h0A;
  localparam logic [7:0] CodeCr     = 8'h0D;

  // Control picture bytes: E2 90 (80 | low code), U+2400 onwards.
  localparam logic [7:0] PicByte0   = 8'hE2;
  localparam logic [7:0] PicByte1   = 8'h90;
  localparam logic [7:0] PicByte2   = 8'h80;
  localparam logic [5:0] PicDelCode = 6'h21;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_paste;
  } in_item_t;

  typedef struct packed {
    logic [7:0]          out_byte;
    logic                byte_valid;
    logic                last_of_run;
    logic [RptWidth-1:0] removed_count;
  } out_item_t;

  // Five-character bracketed tag for a bidi control, first character in the top byte.
  function automatic logic [39:0] bidi_label(input logic [3:0] idx);
    logic [39:0] tag;
    unique case (idx)
      4'd0:    tag = "[LRE]";
      4'd1:    tag = "[RLE]";
      4'd2:    tag = "[PDF]";
      4'd3:    tag = "[LRO]";
      4'd4:    tag = "[RLO]";
      4'd5:    tag = "[LRI]";
      4'd6:    tag = "[RLI]";
      4'd7:    tag = "[FSI]";
      4'd8:    tag = "[PDI]";
      default: tag = '0;
    endcase
    return tag;
  endfunction

endpackage

@@ sv/control_char_strip_or_show.sv @@
// Channel  | Direction | Handshake               | Payload
// in       | input     | in_valid_i / in_stall_o  | in_data_i  (ccs_pkg::in_item_t)
// out      | output    | out_valid_o / out_stall_i| out_data_o (ccs_pkg::out_item_t)
// cfg      | input     | cfg_valid_i / cfg_ready_o| cfg_data_i (show mode)
//
// Each accepted byte is classified in the cycle it is taken and its results land in a
// result buffer; the first result is offered on the next cycle.
// An input transaction causing k results holds the output until all k leave; the next byte is
// taken in the cycle the last leaves; unstalled, single-result bytes flow at one per cycle.
// Bytes that cause no result and are not an end of paste are absorbed without output.
// Reset clears the held prefix, the counter, the show mode and the result buffer.
// A stalled output holds its transaction; input is stalled while results remain.
module control_char_strip_or_show (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ccs_pkg::in_item_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ccs_pkg::out_item_t   out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_data_i
);

  logic                               show_q;
  logic [7:0]                         held_q [2];
  logic [7:0]                         held_d [2];
  logic [1:0]                         held_cnt_q, held_cnt_d;
  logic [ccs_pkg::COUNT_WIDTH-1:0]    total_q, total_d, total_now;
  logic [7:0]                         obuf_q [ccs_pkg::MaxOut];
  logic [7:0]                         obuf_d [ccs_pkg::MaxOut];
  logic [ccs_pkg::OutIdxW-1:0]        res_n_q, res_n_d, idx_q;
  logic [ccs_pkg::RptWidth-1:0]       rpt_q;
  logic                               blank_q, blank_d;
  logic                               in_take, out_take, last_res;
  logic [ccs_pkg::CountExtW-1:0]      total_ext;

  // Handshake control.
  assign out_valid_o = (res_n_q != '0);
  assign last_res    = ((idx_q + ccs_pkg::OutIdxW'(1)) == res_n_q);
  assign out_take    = out_valid_o && !out_stall_i;
  assign in_stall_o  = out_valid_o && !(last_res && out_take);
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Classification of the window of held bytes plus the new byte.
  always_comb begin : proc_classify
    logic [7:0]                  w [4];
    logic [1:0]                  win_n, pos, hold_pos;
    logic                        stop, hold, is_end;
    logic [7:0]                  c, nxt, nxt2;
    logic                        have1, have2, is_ctrl, is_bidi;
    logic [5:0]                  pic_code;
    logic [3:0]                  bidi_idx;
    logic [7:0]                  seg [5];
    logic [2:0]                  seg_len;
    logic [1:0]                  adv, inc;
    logic [2:0]                  oc;
    logic [39:0]                 tag;
    logic [ccs_pkg::COUNT_WIDTH:0] sum;

    is_end = in_data_i.end_of_paste;
    win_n  = held_cnt_q + 2'd1;
    w[0]   = (held_cnt_q == 2'd0) ? in_data_i.in_byte : held_q[0];
    w[1]   = (held_cnt_q == 2'd1) ? in_data_i.in_byte : held_q[1];
    w[2]   = in_data_i.in_byte;
    w[3]   = '0;
    pos      = '0;
    hold_pos = '0;
    stop     = 1'b0;
    hold     = 1'b0;
    oc       = '0;
    inc      = '0;
    tag      = '0;
    for (int m = 0; m < ccs_pkg::MaxOut; m++) obuf_d[m] = '0;

    for (int s = 0; s < 3; s++) begin
      c        = w[pos];
      nxt      = w[pos + 2'd1];
      nxt2     = w[pos + 2'd2];
      have1    = ({1'b0, pos} + 3'd1) < {1'b0, win_n};
      have2    = ({1'b0, pos} + 3'd2) < {1'b0, win_n};
      is_ctrl  = 1'b0;
      is_bidi  = 1'b0;
      pic_code = '0;
      bidi_idx = '0;
      adv      = 2'd1;
      seg_len  = '0;
      for (int j = 0; j < 5; j++) seg[j] = '0;

      if (!stop && ({1'b0, pos} < {1'b0, win_n})) begin
        priority if (c == ccs_pkg::LeadC1 && have1 &&
                     nxt >= ccs_pkg::C1Low && nxt <= ccs_pkg::C1High) begin
          is_ctrl  = 1'b1;
          pic_code = {1'b0, nxt[4:0]};
          adv      = 2'd2;
        end else if (c == ccs_pkg::LeadC1 && !have1 && !is_end) begin
          hold = 1'b1;
        end else if (c == ccs_pkg::LeadE2 && have2 && nxt == ccs_pkg::Mid80 &&
                     nxt2 >= ccs_pkg::EmbedLow && nxt2 <= ccs_pkg::EmbedHigh) begin
          is_bidi  = 1'b1;
          bidi_idx = 4'(nxt2 - ccs_pkg::EmbedLow);
          adv      = 2'd3;
        end else if (c == ccs_pkg::LeadE2 && have2 && nxt == ccs_pkg::Mid81 &&
                     nxt2 >= ccs_pkg::IsoLow && nxt2 <= ccs_pkg::IsoHigh) begin
          is_bidi  = 1'b1;
          bidi_idx = 4'(nxt2 - ccs_pkg::IsoLow) + 4'd5;
          adv      = 2'd3;
        end else if (c == ccs_pkg::LeadE2 && !have2 && !is_end &&
                     (!have1 || nxt == ccs_pkg::Mid80 || nxt == ccs_pkg::Mid81)) begin
          hold = 1'b1;
        end else if ((c < ccs_pkg::CodeSpace && c != ccs_pkg::CodeTab &&
                      c != ccs_pkg::CodeLf && c != ccs_pkg::CodeCr) ||
                     c == ccs_pkg::CodeDel) begin
          is_ctrl  = 1'b1;
          pic_code = (c == ccs_pkg::CodeDel) ? ccs_pkg::PicDelCode : {1'b0, c[4:0]};
        end else begin
          seg[0]  = c;
          seg_len = 3'd1;
        end

        // A matched control counts once and, when shown, becomes a picture or a tag.
        if (is_ctrl) begin
          inc = inc + 2'd1;
          if (show_q) begin
            seg[0]  = ccs_pkg::PicByte0;
            seg[1]  = ccs_pkg::PicByte1;
            seg[2]  = ccs_pkg::PicByte2 | {2'b00, pic_code};
            seg_len = 3'd3;
          end
        end
        if (is_bidi) begin
          inc = inc + 2'd1;
          if (show_q) begin
            tag = ccs_pkg::bidi_label(bidi_idx);
            for (int j = 0; j < 5; j++) seg[j] = tag[39 - 8*j -: 8];
            seg_len = 3'd5;
          end
        end

        if (hold) begin
          stop     = 1'b1;
          hold_pos = pos;
        end else begin
          for (int j = 0; j < 5; j++) begin
            if (3'(j) < seg_len && oc < 3'(ccs_pkg::MaxOut)) begin
              obuf_d[oc] = seg[j];
              oc         = oc + 3'd1;
            end
          end
          pos = pos + adv;
        end
      end
    end

    // Prefix kept for the next byte.
    held_d[0] = w[hold_pos];
    held_d[1] = w[hold_pos + 2'd1];
    held_cnt_d = hold ? (win_n - hold_pos) : 2'd0;

    // Saturating count of matched controls.
    sum = {1'b0, total_q} + (ccs_pkg::COUNT_WIDTH + 1)'(inc);
    total_now = sum[ccs_pkg::COUNT_WIDTH] ? '1 : sum[ccs_pkg::COUNT_WIDTH-1:0];
    total_d   = is_end ? '0 : total_now;

    // An end of paste with no bytes still gives one empty transaction.
    blank_d = (oc == 3'd0) && is_end;
    res_n_d = blank_d ? ccs_pkg::OutIdxW'(1) : ccs_pkg::OutIdxW'(oc);
  end

  assign total_ext = ccs_pkg::CountExtW'(total_now);

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      show_q     <= 1'b0;
      held_cnt_q <= '0;
      total_q    <= '0;
      res_n_q    <= '0;
      idx_q      <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        show_q <= cfg_data_i;
      end
      if (in_take) begin
        held_cnt_q <= held_cnt_d;
        total_q    <= total_d;
        res_n_q    <= res_n_d;
        idx_q      <= '0;
      end else if (out_take) begin
        if (last_res) begin
          res_n_q <= '0;
          idx_q   <= '0;
        end else begin
          idx_q <= idx_q + ccs_pkg::OutIdxW'(1);
        end
      end
    end
  end

  // Result buffer and held bytes: payload only.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      held_q[0] <= held_d[0];
      held_q[1] <= held_d[1];
      obuf_q    <= obuf_d;
      blank_q   <= blank_d;
      rpt_q     <= total_ext[ccs_pkg::RptWidth-1:0];
    end
  end

  // Result transaction.
  assign out_data_o.out_byte      = obuf_q[idx_q];
  assign out_data_o.byte_valid    = !blank_q;
  assign out_data_o.last_of_run   = last_res;
  assign out_data_o.removed_count = rpt_q;

  // An empty transaction is always the last of its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.byte_valid) |-> out_data_o.last_of_run)
    else $error("empty result is not flagged last");

  // A new byte is only taken when the final pending result leaves.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && out_valid_o) |-> (last_res && !out_stall_i))
    else $error("input accepted over pending results");

  // At most two bytes are ever held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_cnt_q != 2'd3)
    else $error("held count out of range");

  // An end of paste leaves nothing held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && in_data_i.end_of_paste) |=> (held_cnt_q == 2'd0))
    else $error("bytes held across end of paste");

endmodule

@@ verif/tb_control_char_strip_or_show.sv @@
`timescale 1ns / 100ps

module tb_control_char_strip_or_show;

  localparam int unsigned ClkPeriod    = 10;
  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned PhaseItems   = 16;
  localparam logic [15:0] PictureBase  = 16'h2400;
  localparam logic [15:0] PictureDel   = 16'h2421;

  // Shapes of text that the random part strings together.
  typedef enum int unsigned {
    SeqPlain, SeqC0, SeqDel, SeqC1, SeqBidi, SeqBroken, SeqNoise
  } seq_kind_e;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  ccs_pkg::in_item_t  in_data   = '0;
  logic               in_stall;
  logic               out_valid;
  ccs_pkg::out_item_t out_data;
  logic               rx_stall  = 1'b0;
  logic               hold_off  = 1'b0;
  wire                out_stall = rx_stall | hold_off;
  logic               cfg_valid = 1'b0;
  logic               cfg_data  = 1'b0;
  logic               cfg_ready;

  bit          idle_en     = 1'b1;
  int unsigned error_count = 0;
  int unsigned items_sent  = 0;
  event        hold_go;

  // Predicted state of the filter.
  logic                            show_q    = 1'b0;
  logic [7:0]                      held_q [2];
  int unsigned                     held_n    = 0;
  logic [ccs_pkg::COUNT_WIDTH-1:0] removed_q = '0;
  logic [7:0]                      step_bytes [$];
  ccs_pkg::out_item_t              expected_q [$];

  always #(ClkPeriod / 2) clk = ~clk;

  control_char_strip_or_show u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  // Every recognised control bumps the count, which sticks at all ones.
  task automatic count_control();
    if (removed_q != '1) removed_q++;
  endtask

  // C0, C1 and DEL map onto the control pictures; C1 folds onto C0.
  task automatic add_picture(input logic [7:0] code);
    logic [15:0] cp;
    count_control();
    if (code == ccs_pkg::CodeDel) cp = PictureDel;
    else cp = PictureBase + 16'(code[4:0]);
    if (show_q) begin
      step_bytes.push_back({4'hE, cp[15:12]});
      step_bytes.push_back({2'b10, cp[11:6]});
      step_bytes.push_back({2'b10, cp[5:0]});
    end
  endtask

  // Embeddings and overrides come first (0 to 4), then the isolates (5 to 8).
  task automatic add_tag(input int unsigned idx);
    logic [39:0] tag;
    count_control();
    case (idx)
      0:       tag = "[LRE]";
      1:       tag = "[RLE]";
      2:       tag = "[PDF]";
      3:       tag = "[LRO]";
      4:       tag = "[RLO]";
      5:       tag = "[LRI]";
      6:       tag = "[RLI]";
      7:       tag = "[FSI]";
      default: tag = "[PDI]";
    endcase
    if (show_q) begin
      for (int k = 0; k < 5; k++) step_bytes.push_back(tag[39 - 8 * k -: 8]);
    end
  endtask

  // Works out the result transactions that one accepted byte causes.
  task automatic predict_paste(input ccs_pkg::in_item_t item);
    logic [7:0]         win [3];
    logic [7:0]         c;
    int unsigned        n, i, k, used;
    bit                 keep_held, eop;
    ccs_pkg::out_item_t r;
    eop       = item.end_of_paste;
    n         = 0;
    i         = 0;
    keep_held = 1'b0;
    for (k = 0; k < held_n; k++) begin
      win[n] = held_q[k];
      n++;
    end
    win[n] = item.in_byte;
    n++;
    held_n = 0;
    step_bytes.delete();

    // Classify the window; a failed prefix goes out byte by byte.
    while (i < n && !keep_held) begin
      c    = win[i];
      used = 1;
      if (c == ccs_pkg::LeadC1 && i + 1 < n &&
          win[i+1] >= ccs_pkg::C1Low && win[i+1] <= ccs_pkg::C1High) begin
        add_picture(win[i+1]);
        used = 2;
      end else if (c == ccs_pkg::LeadC1 && i + 1 >= n && !eop) begin
        keep_held = 1'b1;
        used      = 0;
      end else if (c == ccs_pkg::LeadE2 && i + 2 < n && win[i+1] == ccs_pkg::Mid80 &&
                   win[i+2] >= ccs_pkg::EmbedLow && win[i+2] <= ccs_pkg::EmbedHigh) begin
        add_tag(win[i+2] - ccs_pkg::EmbedLow);
        used = 3;
      end else if (c == ccs_pkg::LeadE2 && i + 2 < n && win[i+1] == ccs_pkg::Mid81 &&
                   win[i+2] >= ccs_pkg::IsoLow && win[i+2] <= ccs_pkg::IsoHigh) begin
        add_tag(5 + (win[i+2] - ccs_pkg::IsoLow));
        used = 3;
      end else if (c == ccs_pkg::LeadE2 && i + 2 >= n && !eop &&
                   (i + 1 == n || win[i+1] == ccs_pkg::Mid80 ||
                    win[i+1] == ccs_pkg::Mid81)) begin
        keep_held = 1'b1;
        used      = 0;
      end else if ((c < ccs_pkg::CodeSpace && c != ccs_pkg::CodeTab &&
                    c != ccs_pkg::CodeLf && c != ccs_pkg::CodeCr) ||
                   c == ccs_pkg::CodeDel) begin
        add_picture(c);
      end else begin
        step_bytes.push_back(c);
      end
      i += used;
    end

    if (keep_held) begin
      for (k = 0; i + k < n && k < 2; k++) held_q[k] = win[i+k];
      held_n = k;
    end

    // An end of paste that yields nothing still produces an empty marker.
    r.removed_count = ccs_pkg::RptWidth'(removed_q);
    if (step_bytes.size() == 0 && eop) begin
      r.out_byte    = '0;
      r.byte_valid  = 1'b0;
      r.last_of_run = 1'b1;
      expected_q.push_back(r);
    end else begin
      foreach (step_bytes[j]) begin
        r.out_byte    = step_bytes[j];
        r.byte_valid  = 1'b1;
        r.last_of_run = (j == step_bytes.size() - 1);
        expected_q.push_back(r);
      end
    end
    if (eop) begin
      removed_q = '0;
      held_n    = 0;
    end
  endtask

  // Offers one byte after a random gap and holds it until it is taken.
  task automatic send_byte(input logic [7:0] b, input bit eop);
    int unsigned gap;
    gap = idle_en ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_byte: b, end_of_paste: eop};
    do @(posedge clk); while (in_stall);
    predict_paste(in_data);
    items_sent++;
    @(negedge clk);
  endtask

  // Waits until every predicted result has left, then lets absorbed bytes settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_show_mode(input logic mode);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    show_q = mode;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Strip mode: C0, tab, DEL, ordinary bytes and an end that yields nothing.
  task automatic test_strip_directed();
    write_show_mode(1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(ccs_pkg::CodeTab, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(ccs_pkg::CodeDel, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(ccs_pkg::LeadC1, 1'b0);
    send_byte(ccs_pkg::C1High, 1'b1);
  endtask

  // Show mode: pictures, tags, failed prefixes and flushing at the end.
  task automatic test_show_directed();
    write_show_mode(1'b1);
    send_byte(ccs_pkg::LeadC1, 1'b0);
    send_byte(ccs_pkg::C1Low, 1'b0);
    send_byte(ccs_pkg::LeadE2, 1'b0);
    send_byte(ccs_pkg::Mid80, 1'b0);
    send_byte(ccs_pkg::EmbedLow, 1'b0);
    send_byte(ccs_pkg::LeadE2, 1'b0);
    send_byte(ccs_pkg::Mid81, 1'b0);
    send_byte(ccs_pkg::IsoHigh, 1'b0);
    // A C1 lead followed by a letter is two ordinary bytes.
    send_byte(ccs_pkg::LeadC1, 1'b0);
    send_byte(8'h41, 1'b0);
    // Two held bytes that fail on the third.
    send_byte(ccs_pkg::LeadE2, 1'b0);
    send_byte(ccs_pkg::Mid80, 1'b0);
    send_byte(8'hAF, 1'b0);
    // E2 followed by LF fails at once; LF itself passes.
    send_byte(ccs_pkg::LeadE2, 1'b0);
    send_byte(ccs_pkg::CodeLf, 1'b0);
    send_byte(ccs_pkg::CodeDel, 1'b0);
    send_byte(8'h1F, 1'b0);
    // An incomplete prefix at the end of a paste goes out unchanged.
    send_byte(ccs_pkg::LeadE2, 1'b0);
    send_byte(ccs_pkg::Mid80, 1'b1);
  endtask

  // Several kinds of control in one paste build up the count, which clears at the end.
  task automatic test_count_clear();
    write_show_mode(1'b0);
    idle_en = 1'b0;
    send_byte(8'h01, 1'b0);
    send_byte(ccs_pkg::LeadC1, 1'b0);
    send_byte(8'h85, 1'b0);
    send_byte(ccs_pkg::LeadE2, 1'b0);
    send_byte(ccs_pkg::Mid81, 1'b0);
    send_byte(ccs_pkg::IsoLow, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(ccs_pkg::CodeDel, 1'b1);
    send_byte(8'h41, 1'b1);
    idle_en = 1'b1;
  endtask

  // Random text, mostly well-formed sequences, in several mode and idling phases.
  task automatic test_random_text();
    seq_kind_e   kind;
    bit          eop;
    int unsigned phase_first, pick;
    logic [7:0]  lead;
    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 3) write_show_mode(1'($urandom_range(0, 1)));
      else write_show_mode(phase % 2 == 0);
      idle_en     = (phase != 2);
      phase_first = items_sent;
      while (items_sent - phase_first < PhaseItems) begin
        kind = seq_kind_e'($urandom_range(SeqPlain, SeqNoise));
        eop  = ($urandom_range(0, 9) == 0);
        case (kind)
          SeqPlain: send_byte(8'($urandom_range(32, 126)), eop);
          SeqC0:    send_byte(8'($urandom_range(0, 31)), eop);
          SeqDel:   send_byte(ccs_pkg::CodeDel, eop);
          SeqC1: begin
            send_byte(ccs_pkg::LeadC1, 1'b0);
            send_byte(8'($urandom_range(ccs_pkg::C1Low, ccs_pkg::C1High)), eop);
          end
          SeqBidi: begin
            send_byte(ccs_pkg::LeadE2, 1'b0);
            if ($urandom_range(0, 1)) begin
              send_byte(ccs_pkg::Mid80, 1'b0);
              send_byte(8'($urandom_range(ccs_pkg::EmbedLow, ccs_pkg::EmbedHigh)), eop);
            end else begin
              send_byte(ccs_pkg::Mid81, 1'b0);
              send_byte(8'($urandom_range(ccs_pkg::IsoLow, ccs_pkg::IsoHigh)), eop);
            end
          end
          SeqBroken: begin
            // A prefix, sometimes cut by the end of the paste, then a mid byte or any byte.
            pick = $urandom_range(0, 2);
            lead = (pick == 0) ? ccs_pkg::LeadC1 : ccs_pkg::LeadE2;
            if ($urandom_range(0, 3) == 0) begin
              send_byte(lead, 1'b1);
            end else begin
              send_byte(lead, 1'b0);
              if (pick == 2) begin
                send_byte($urandom_range(0, 1) ? ccs_pkg::Mid80 : ccs_pkg::Mid81, eop);
              end else begin
                send_byte(8'($urandom), eop);
              end
            end
          end
          default: send_byte(8'($urandom), eop);
        endcase
      end
      send_byte(8'($urandom), 1'b1);
    end
    idle_en = 1'b1;
  endtask

  // The receiver holds off for a long stretch while multi-byte results pile up.
  task automatic test_output_hold_off();
    write_show_mode(1'b1);
    idle_en = 1'b0;
    -> hold_go;
    repeat (6) begin
      send_byte(ccs_pkg::LeadE2, 1'b0);
      send_byte(ccs_pkg::Mid80, 1'b0);
      send_byte(8'hAB, 1'b0);
      send_byte(8'h01, 1'b0);
    end
    send_byte(8'h41, 1'b1);
    idle_en = 1'b1;
  endtask

  // Long receiver hold-off, counted here so that the sender runs on meanwhile.
  initial begin : output_hold_off
    forever begin
      @(hold_go);
      hold_off <= 1'b1;
      repeat (HoldCycles) @(negedge clk);
      hold_off <= 1'b0;
    end
  end

  // Takes result transactions after a random stall and checks each one.
  initial begin : result_checker
    int unsigned        gap;
    ccs_pkg::out_item_t want;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = idle_en ? $urandom_range(0, 9) : 0;
      if (gap != 0) begin
        rx_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      rx_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      if (expected_q.size() == 0) begin
        error_count++;
        if (error_count <= MaxReports)
          $display("unexpected result: byte %h valid %b last %b count %0d",
                   out_data.out_byte, out_data.byte_valid, out_data.last_of_run,
                   out_data.removed_count);
      end else begin
        want = expected_q.pop_front();
        if (out_data.out_byte !== want.out_byte || out_data.byte_valid !== want.byte_valid ||
            out_data.last_of_run !== want.last_of_run ||
            out_data.removed_count !== want.removed_count) begin
          error_count++;
          if (error_count <= MaxReports)
            $display({"mismatch: expected byte %h valid %b last %b count %0d, ",
                      "got byte %h valid %b last %b count %0d"},
                     want.out_byte, want.byte_valid, want.last_of_run, want.removed_count,
                     out_data.out_byte, out_data.byte_valid, out_data.last_of_run,
                     out_data.removed_count);
        end
      end
    end
  end

  // Ends a run that hangs.
  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk);
    $display("control_char_strip_or_show regression: fail");
    $finish;
  end

  initial begin : regression
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    test_strip_directed();
    test_show_directed();
    test_count_clear();
    test_random_text();
    test_output_hold_off();
    wait_idle();
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("control_char_strip_or_show regression: pass");
    end else begin
      $display("control_char_strip_or_show regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/ccs_pkg.sv
sv/control_char_strip_or_show.sv
verif/tb_control_char_strip_or_show.sv
